@@ rtl/virtual_spring_mass_damper_world_unit_defines.svh @@
// Assertion helpers shared by the RTL; every module using them has clk and arst_n.
`ifndef VIRTUAL_SPRING_MASS_DAMPER_WORLD_UNIT_DEFINES_SVH
`define VIRTUAL_SPRING_MASS_DAMPER_WORLD_UNIT_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define VSMD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define VSMD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/vsmd_pkg.sv @@
package vsmd_pkg;

	// default state word width
	localparam int DEF_WORD_WIDTH = 32;

	// coefficient registers are fixed 32-bit words, consumed two bits a cycle
	localparam int COEF_W     = 32;
	localparam int DIGIT_W    = 2;
	localparam int NUM_DIGITS = COEF_W / DIGIT_W;
	localparam int CNT_W      = $clog2(NUM_DIGITS);

	localparam int IO_W      = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic signed [IO_W-1:0] OUT_MAX = 32'sh7FFF_FFFF;

	// register reset values
	localparam logic [COEF_W-1:0] RST_STIFFNESS      = 32'd1159987;
	localparam logic [COEF_W-1:0] RST_DAMPING        = 32'd1160;
	localparam logic [COEF_W-1:0] RST_STEP_OVER_MASS = 32'd9544371;
	localparam logic [COEF_W-1:0] RST_STEP_PERIOD    = 32'd4294967;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STIFFNESS      = 2'd0,
		CFG_DAMPING        = 2'd1,
		CFG_STEP_OVER_MASS = 2'd2,
		CFG_STEP_PERIOD    = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SPRING,
		ST_DAMP,
		ST_POS,
		ST_VEL,
		ST_TSPRING,
		ST_TDAMP,
		ST_EMIT
	} state_t;

	// multiplier control and status
	typedef struct packed {
		logic start;
		logic frac32;
	} mul_ctl_t;

	typedef struct packed {
		logic done;
		logic clip;
	} mul_sts_t;

endpackage

@@ rtl/vsmd_in_if.sv @@
interface vsmd_in_if;
	logic              valid;
	logic              ready;
	logic signed [31:0] wheel_angle;
	logic signed [31:0] wheel_velocity;

	modport source (output valid, output wheel_angle, output wheel_velocity, input ready);
	modport sink   (input valid, input wheel_angle, input wheel_velocity, output ready);
endinterface

@@ rtl/vsmd_out_if.sv @@
interface vsmd_out_if;
	logic              valid;
	logic              ready;
	logic signed [31:0] torque;
	logic              saturated;

	modport source (output valid, output torque, output saturated, input ready);
	modport sink   (input valid, input torque, input saturated, output ready);
endinterface

@@ rtl/vsmd_mul.sv @@
`include "virtual_spring_mass_damper_world_unit_defines.svh"

// Sign-magnitude multiplier, two coefficient bits per cycle, with truncation
// of 16 or 32 fraction bits and saturation to a signed word.
module vsmd_mul #(
	parameter int WORD_WIDTH = vsmd_pkg::DEF_WORD_WIDTH,
	parameter int OPND_WIDTH = vsmd_pkg::DEF_WORD_WIDTH + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  vsmd_pkg::mul_ctl_t            ctl,
	input  logic signed [OPND_WIDTH-1:0]  opnd,
	input  logic [vsmd_pkg::COEF_W-1:0]   coef,
	output vsmd_pkg::mul_sts_t            sts,
	output logic signed [WORD_WIDTH-1:0]  res
);
	import vsmd_pkg::*;

	localparam int DW = OPND_WIDTH;
	localparam int W  = WORD_WIDTH;
	localparam int RW = DW + COEF_W / 2;

	logic              busy_q, fin_q, done_q, clip_q, neg_q, frac32_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DW-1:0]     mag_q, hi_q;
	logic [DW+1:0]     mag3_q;
	logic [COEF_W-1:0] lo_q;
	logic signed [W-1:0] res_q;

	logic [DW-1:0]   mag_in;
	logic [DW+1:0]   addend, psum;
	logic [RW-1:0]   rsel, lim_ext;
	logic [W-1:0]    lim_w, rc;
	logic            over;

	// magnitude of the incoming operand
	assign mag_in = opnd[DW-1] ? (~opnd + 1'b1) : opnd;

	// one digit of shift-add
	always_comb begin
		case (lo_q[DIGIT_W-1:0])
			2'd0:    addend = '0;
			2'd1:    addend = {2'b00, mag_q};
			2'd2:    addend = {1'b0, mag_q, 1'b0};
			2'd3:    addend = mag3_q;
			default: addend = '0;
		endcase
		psum = {2'b00, hi_q} + addend;
	end

	// fraction drop, clip against the word limit, restore sign
	always_comb begin
		rsel    = frac32_q ? {{(COEF_W/2){1'b0}}, hi_q} : {hi_q, lo_q[COEF_W-1:COEF_W/2]};
		lim_w   = neg_q ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		lim_ext = {{(RW-W){1'b0}}, lim_w};
		over    = rsel > lim_ext;
		rc      = over ? lim_w : rsel[W-1:0];
	end

	// sequencing flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_DIGITS - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
					cnt_q  <= '0;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			neg_q    <= opnd[DW-1];
			frac32_q <= ctl.frac32;
			mag_q    <= mag_in;
			mag3_q   <= {2'b00, mag_in} + {1'b0, mag_in, 1'b0};
			hi_q     <= '0;
			lo_q     <= coef;
		end else if (busy_q) begin
			hi_q <= psum[DW+1:DIGIT_W];
			lo_q <= {psum[DIGIT_W-1:0], lo_q[COEF_W-1:DIGIT_W]};
		end
		if (fin_q) begin
			res_q  <= neg_q ? -rc : rc;
			clip_q <= over;
		end
	end

	assign sts.done = done_q;
	assign sts.clip = clip_q;
	assign res      = res_q;

	`VSMD_ASSERT(a_start_idle, !ctl.start || (!busy_q && !fin_q), "start while multiplying")
	`VSMD_ASSERT(a_hi_bound, !busy_q || (hi_q <= mag_q), "partial sum exceeds magnitude")
	`VSMD_ASSERT(a_clip_lim, !(sts.done && sts.clip) || res == {1'b0, {(W-1){1'b1}}} || res == {1'b1, {(W-1){1'b0}}}, "clipped result off the limit")
	`VSMD_ASSERT(a_cnt_idle, busy_q || cnt_q == '0, "digit count not parked")

endmodule

@@ rtl/virtual_spring_mass_damper_world_unit.sv @@
// Haptic spring-mass-damper world: each request (wheel angle and velocity, Q16.16)
// advances a virtual mass by one forward-Euler step and returns one torque command
// with a flag that is set if any intermediate, state or output value was clipped.
// Each item runs six products one after another on a single shared multiplier that
// consumes two coefficient bits per cycle, and a new request is taken only after the
// result of the last one has been posted. A finished result waits in the output
// register while the next request is taken. Configuration writes take effect at once;
// the user must make them only while the block is idle, which the block itself does
// not enforce.
`include "virtual_spring_mass_damper_world_unit_defines.svh"

module virtual_spring_mass_damper_world_unit #(
	parameter int WORD_WIDTH = vsmd_pkg::DEF_WORD_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [vsmd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vsmd_pkg::COEF_W-1:0]       cfg_data,
	vsmd_in_if.sink                           sample,
	vsmd_out_if.source                        drive
);
	import vsmd_pkg::*;

	localparam int W  = WORD_WIDTH;
	localparam int DW = ((W > IO_W) ? W : IO_W) + 1;

	localparam logic signed [DW-1:0] TRQ_MAX = DW'(OUT_MAX);
	localparam logic signed [DW-1:0] TRQ_MIN = ~TRQ_MAX;
	localparam logic signed [W-1:0]  WMAX    = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0]  WMIN    = {1'b1, {(W-1){1'b0}}};

	state_t state_q, state_d;

	logic [COEF_W-1:0] stiff_q, damp_q, tjm_q, tper_q;

	logic signed [IO_W-1:0] ang_q, vin_q;
	logic signed [W-1:0]    pos_q, vel_q, term_q, force_q, newp_q, newv_q, trq_q;
	logic                   clip_q, wait_q, out_vld_q, out_sat_q;
	logic signed [IO_W-1:0] out_trq_q;

	mul_ctl_t             mctl;
	mul_sts_t             msts;
	logic signed [DW-1:0] mopnd, opa, opb;
	logic [COEF_W-1:0]    mcoef;
	logic signed [W-1:0]  mres;

	logic signed [W-1:0]  add_a, sat_sum;
	logic signed [W:0]    add_sum;
	logic                 add_ovf;

	logic signed [DW-1:0]   trq_ext;
	logic signed [IO_W-1:0] trq_out;
	logic                   trq_clip, emit, accept;

	assign accept       = sample.valid && sample.ready;
	assign sample.ready = (state_q == ST_IDLE);
	assign emit         = (state_q == ST_EMIT) && (!out_vld_q || drive.ready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiff_q <= RST_STIFFNESS;
			damp_q  <= RST_DAMPING;
			tjm_q   <= RST_STEP_OVER_MASS;
			tper_q  <= RST_STEP_PERIOD;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_STIFFNESS:      stiff_q <= cfg_data;
				CFG_DAMPING:        damp_q  <= cfg_data;
				CFG_STEP_OVER_MASS: tjm_q   <= cfg_data;
				CFG_STEP_PERIOD:    tper_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer: next state, multiplier request and operand selection
	always_comb begin
		state_d     = state_q;
		mctl.start  = 1'b0;
		mctl.frac32 = 1'b0;
		opa         = '0;
		opb         = '0;
		mcoef       = stiff_q;
		add_a       = term_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_SPRING;
			end
			ST_SPRING: begin
				opa   = DW'(ang_q);
				opb   = DW'(pos_q);
				mcoef = stiff_q;
				if (msts.done) state_d = ST_DAMP;
			end
			ST_DAMP: begin
				opa   = DW'(vin_q);
				opb   = DW'(vel_q);
				mcoef = damp_q;
				add_a = term_q;
				if (msts.done) state_d = ST_POS;
			end
			ST_POS: begin
				opa         = DW'(vel_q);
				mcoef       = tper_q;
				mctl.frac32 = 1'b1;
				add_a       = pos_q;
				if (msts.done) state_d = ST_VEL;
			end
			ST_VEL: begin
				opa         = DW'(force_q);
				mcoef       = tjm_q;
				mctl.frac32 = 1'b1;
				add_a       = vel_q;
				if (msts.done) state_d = ST_TSPRING;
			end
			ST_TSPRING: begin
				opa   = DW'(newp_q);
				opb   = DW'(ang_q);
				mcoef = stiff_q;
				if (msts.done) state_d = ST_TDAMP;
			end
			ST_TDAMP: begin
				opa   = DW'(newv_q);
				opb   = DW'(vin_q);
				mcoef = damp_q;
				add_a = term_q;
				if (msts.done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		if (state_q != ST_IDLE && state_q != ST_EMIT) mctl.start = !wait_q;
	end

	assign mopnd = opa - opb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	vsmd_mul #(
		.WORD_WIDTH (W),
		.OPND_WIDTH (DW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mctl),
		.opnd   (mopnd),
		.coef   (mcoef),
		.sts    (msts),
		.res    (mres)
	);

	// shared saturating adder
	assign add_sum = {add_a[W-1], add_a} + {mres[W-1], mres};
	assign add_ovf = add_sum[W] ^ add_sum[W-1];
	assign sat_sum = add_ovf ? (add_sum[W] ? WMIN : WMAX) : add_sum[W-1:0];

	// final clip to the 32-bit output range
	assign trq_ext  = DW'(trq_q);
	assign trq_clip = (trq_ext > TRQ_MAX) || (trq_ext < TRQ_MIN);
	assign trq_out  = (trq_ext > TRQ_MAX) ? OUT_MAX :
	                  (trq_ext < TRQ_MIN) ? ~OUT_MAX : trq_ext[IO_W-1:0];

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q    <= 1'b0;
			out_vld_q <= 1'b0;
			pos_q     <= '0;
			vel_q     <= '0;
		end else begin
			if (mctl.start)     wait_q <= 1'b1;
			else if (msts.done) wait_q <= 1'b0;
			if (emit) begin
				out_vld_q <= 1'b1;
				pos_q     <= newp_q;
				vel_q     <= newv_q;
			end else if (drive.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// working values and result
	always_ff @(posedge clk) begin
		if (accept) begin
			ang_q  <= sample.wheel_angle;
			vin_q  <= sample.wheel_velocity;
			clip_q <= 1'b0;
		end
		if (msts.done) begin
			clip_q <= clip_q | msts.clip | ((state_q != ST_SPRING && state_q != ST_TSPRING) && add_ovf);
			case (state_q)
				ST_SPRING:  term_q  <= mres;
				ST_DAMP:    force_q <= sat_sum;
				ST_POS:     newp_q  <= sat_sum;
				ST_VEL:     newv_q  <= sat_sum;
				ST_TSPRING: term_q  <= mres;
				ST_TDAMP:   trq_q   <= sat_sum;
				default: ;
			endcase
		end
		if (emit) begin
			out_trq_q <= trq_out;
			out_sat_q <= clip_q | trq_clip;
		end
	end

	assign drive.valid     = out_vld_q;
	assign drive.torque    = out_trq_q;
	assign drive.saturated = out_sat_q;

	`VSMD_ASSERT(a_done_in_mul, !msts.done || (state_q == ST_SPRING || state_q == ST_DAMP || state_q == ST_POS || state_q == ST_VEL || state_q == ST_TSPRING || state_q == ST_TDAMP), "product outside a multiply state")
	`VSMD_ASSERT_NEXT(a_emit_valid, emit, drive.valid, "result not posted after emit")
	`VSMD_ASSERT_NEXT(a_one_start, mctl.start, !mctl.start, "back-to-back multiplier starts")

endmodule

@@ test/vsmd_torque_checker.sv @@
`timescale 1ns / 100ps

// Watches the request, result and register-write ports of the haptic world block.
// It keeps its own copy of the mass state and coefficients and predicts one torque
// command per accepted request. Each accepted result is compared against the oldest
// prediction.
module vsmd_torque_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [vsmd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vsmd_pkg::COEF_W-1:0]    cfg_data,
	vsmd_in_if                             sample,
	vsmd_out_if                            drive,
	output int                             mismatches,
	output int                             pending
);
	import vsmd_pkg::*;

	localparam int     WORD_W   = DEF_WORD_WIDTH;
	localparam longint WORD_TOP = (longint'(1) <<< (WORD_W - 1)) - 1;
	localparam longint WORD_BOT = -WORD_TOP - 1;
	localparam longint TQ_TOP   = OUT_MAX;
	localparam longint TQ_BOT   = -TQ_TOP - 1;

	typedef struct packed {
		logic signed [IO_W-1:0] torque;
		logic                   saturated;
	} torque_cmd_t;

	torque_cmd_t torque_due[$];

	// coefficient copies and virtual mass state
	logic [COEF_W-1:0] k_coef, b_coef, tj_coef, t_coef;
	longint            mass_pos, mass_vel;
	bit                tick_clip;

	initial mismatches = 0;
	initial pending = 0;

	// saturate a sum to the state word
	function automatic longint clip_word(input longint v);
		if (v > WORD_TOP) begin
			tick_clip = 1'b1;
			return WORD_TOP;
		end
		if (v < WORD_BOT) begin
			tick_clip = 1'b1;
			return WORD_BOT;
		end
		return v;
	endfunction

	// a * coef >> frac_bits, magnitude truncated toward zero, saturated to the word
	function automatic longint scale(input longint a, input logic [COEF_W-1:0] coef,
			input int frac_bits);
		bit           neg;
		longint       mag;
		logic [127:0] prod;
		logic [127:0] lim;
		neg  = a < 0;
		mag  = neg ? -a : a;
		prod = {64'd0, mag} * {96'd0, coef};
		prod = prod >> frac_bits;
		lim  = neg ? 128'(WORD_TOP) + 128'd1 : 128'(WORD_TOP);
		if (prod > lim) begin
			tick_clip = 1'b1;
			prod = lim;
		end
		return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
	endfunction

	// one forward-Euler tick of the mass, then the torque toward it
	function automatic torque_cmd_t predict_torque(input logic signed [IO_W-1:0] angle,
			input logic signed [IO_W-1:0] velocity);
		longint      ang, vel, spring, damper, net_force, pos_next, vel_next, tq;
		torque_cmd_t r;
		ang = angle;
		vel = velocity;
		tick_clip = 1'b0;

		spring    = scale(ang - mass_pos, k_coef, 16);
		damper    = scale(vel - mass_vel, b_coef, 16);
		net_force = clip_word(spring + damper);
		pos_next  = clip_word(mass_pos + scale(mass_vel, t_coef, 32));
		vel_next  = clip_word(mass_vel + scale(net_force, tj_coef, 32));

		spring = scale(pos_next - ang, k_coef, 16);
		damper = scale(vel_next - vel, b_coef, 16);
		tq     = clip_word(spring + damper);
		// output range, only narrower than the word when the word is wide
		if (tq > TQ_TOP) begin
			tick_clip = 1'b1;
			tq = TQ_TOP;
		end
		if (tq < TQ_BOT) begin
			tick_clip = 1'b1;
			tq = TQ_BOT;
		end

		mass_pos = pos_next;
		mass_vel = vel_next;
		r.torque    = tq[IO_W-1:0];
		r.saturated = tick_clip;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		torque_cmd_t want;
		if (!arst_n) begin
			k_coef   = RST_STIFFNESS;
			b_coef   = RST_DAMPING;
			tj_coef  = RST_STEP_OVER_MASS;
			t_coef   = RST_STEP_PERIOD;
			mass_pos = 0;
			mass_vel = 0;
			torque_due.delete();
			pending = 0;
		end else begin
			// result side: compare against the oldest prediction
			if (drive.valid && drive.ready) begin
				if (torque_due.size() == 0) begin
					mismatches++;
					$display("%0t: result with no request outstanding: torque %0d saturated %0b",
						$time, drive.torque, drive.saturated);
				end else begin
					want = torque_due.pop_front();
					if (drive.torque !== want.torque || drive.saturated !== want.saturated) begin
						mismatches++;
						$display("%0t: torque/saturated expected %0d/%0b, got %0d/%0b",
							$time, want.torque, want.saturated, drive.torque, drive.saturated);
					end
				end
			end

			// request side
			if (sample.valid && sample.ready)
				torque_due.push_back(predict_torque(sample.wheel_angle, sample.wheel_velocity));

			// coefficient writes take effect at once
			if (cfg_wr_en) begin
				case (cfg_idx_t'(cfg_index))
					CFG_STIFFNESS:      k_coef  = cfg_data;
					CFG_DAMPING:        b_coef  = cfg_data;
					CFG_STEP_OVER_MASS: tj_coef = cfg_data;
					CFG_STEP_PERIOD:    t_coef  = cfg_data;
					default: ;
				endcase
			end

			pending = torque_due.size();
		end
	end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;
	import vsmd_pkg::*;

	localparam int RESET_CYCLES   = 6;
	localparam int HOLD_CYCLES    = 600;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 130;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 46;

	localparam logic signed [IO_W-1:0] S_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [IO_W-1:0] S_MIN = 32'sh8000_0000;
	localparam logic [COEF_W-1:0]      C_MAX = 32'hFFFF_FFFF;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COEF_W-1:0]    cfg_data;

	vsmd_in_if  sample_bus ();
	vsmd_out_if drive_bus ();

	int mismatches;
	int pending;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit hold_pending   = 1'b0;
	int hold_left      = 0;
	int quiet_cycles   = 0;

	virtual_spring_mass_damper_world_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_bus),
		.drive     (drive_bus)
	);

	vsmd_torque_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample     (sample_bus),
		.drive      (drive_bus),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// watchdog: too long without any request or result moving
	always @(posedge clk) begin
		if ((sample_bus.valid && sample_bus.ready) || (drive_bus.valid && drive_bus.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		drive_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				drive_bus.ready <= 1'b0;
			end else begin
				drive_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// angle or velocity: mostly a realistic range, some full-scale and corner values
	function automatic logic signed [IO_W-1:0] pick_level();
		int                     sel;
		logic signed [IO_W-1:0] v;
		sel = $urandom_range(99);
		if (sel < 50) begin
			v = $urandom_range(20'hF_FFFF);
			v = v - 32'sh0008_0000;
		end else if (sel < 75) begin
			v = $urandom;
		end else if (sel < 90) begin
			if ($urandom_range(1))
				v = S_MAX - $urandom_range(255);
			else
				v = S_MIN + $urandom_range(255);
		end else begin
			v = $urandom_range(2);
			v = v - 1;
		end
		return v;
	endfunction

	// coefficient: mostly near its nominal value, some full range and extremes
	function automatic logic [COEF_W-1:0] pick_coef(input logic [COEF_W-1:0] nominal);
		int sel;
		sel = $urandom_range(99);
		if (sel < 60)
			return $urandom_range(2 * nominal);
		else if (sel < 75)
			return $urandom;
		else if (sel < 85)
			return '0;
		else if (sel < 95)
			return C_MAX;
		return nominal;
	endfunction

	// one request; valid stays high when the next request follows directly
	task automatic offer_request(input logic signed [IO_W-1:0] ang,
			input logic signed [IO_W-1:0] vel);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_bus.valid <= 1'b0;
			@(negedge clk);
		end
		sample_bus.valid          <= 1'b1;
		sample_bus.wheel_angle    <= ang;
		sample_bus.wheel_velocity <= vel;
		do @(posedge clk); while (!sample_bus.ready);
		@(negedge clk);
	endtask

	// stop offering and wait until every predicted torque has come back
	task automatic wait_results_done();
		sample_bus.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	// changed away from the falling edge, where the result side reads them
	task automatic set_traffic(input int send_pct, input int stall_pct, input bit long_hold);
		@(posedge clk);
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
		hold_pending   = long_hold;
		@(negedge clk);
	endtask

	task automatic put_reg(input cfg_idx_t idx, input logic [COEF_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
	endtask

	task automatic load_coeffs(input logic [COEF_W-1:0] k, input logic [COEF_W-1:0] b,
			input logic [COEF_W-1:0] tj, input logic [COEF_W-1:0] t);
		put_reg(CFG_STIFFNESS, k);
		put_reg(CFG_DAMPING, b);
		put_reg(CFG_STEP_OVER_MASS, tj);
		put_reg(CFG_STEP_PERIOD, t);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		int ph;
		int n;
		arst_n                    = 1'b0;
		cfg_wr_en                 = 1'b0;
		cfg_index                 = CFG_STIFFNESS;
		cfg_data                  = '0;
		sample_bus.valid          = 1'b0;
		sample_bus.wheel_angle    = '0;
		sample_bus.wheel_velocity = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// reset coefficients: input corners starting from a mass at rest
		set_traffic(0, 0, 1'b0);
		offer_request(32'sd0, 32'sd0);
		offer_request(S_MAX, 32'sd0);
		offer_request(S_MIN, 32'sd0);
		offer_request(32'sd0, S_MAX);
		offer_request(32'sd0, S_MIN);
		offer_request(S_MAX, S_MAX);
		offer_request(S_MIN, S_MIN);
		offer_request(S_MAX, S_MIN);
		offer_request(S_MIN, S_MAX);
		offer_request(32'sh0001_0000, 32'sd0);
		offer_request(-32'sd1, 32'sd1);
		offer_request(32'sd0, 32'sd0);

		// random phases, each with its own coefficients and traffic pattern
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_results_done();
			case (ph % 4)
				0: set_traffic(0, 0, ph == 4);
				1: set_traffic(67, 0, 1'b0);
				2: set_traffic(0, 67, 1'b0);
				default: set_traffic(16, 16, 1'b0);
			endcase
			load_coeffs(pick_coef(RST_STIFFNESS), pick_coef(RST_DAMPING),
				pick_coef(RST_STEP_OVER_MASS), pick_coef(RST_STEP_PERIOD));
			for (n = 0; n < PHASE_ITEMS; n++)
				offer_request(pick_level(), pick_level());
		end

		// all coefficients zero: state frozen, torque zero
		wait_results_done();
		set_traffic(16, 16, 1'b0);
		load_coeffs('0, '0, '0, '0);
		offer_request(S_MAX, S_MIN);
		offer_request(S_MIN, S_MAX);
		offer_request(32'sd0, 32'sd0);
		offer_request(pick_level(), pick_level());

		// all coefficients at full scale: heavy clipping
		wait_results_done();
		load_coeffs(C_MAX, C_MAX, C_MAX, C_MAX);
		offer_request(S_MAX, S_MAX);
		offer_request(S_MIN, S_MIN);
		offer_request(S_MAX, S_MIN);
		offer_request(S_MIN, S_MAX);
		offer_request(32'sd0, 32'sd0);
		offer_request(32'sd1, -32'sd1);

		// back to nominal coefficients
		wait_results_done();
		load_coeffs(RST_STIFFNESS, RST_DAMPING, RST_STEP_OVER_MASS, RST_STEP_PERIOD);
		offer_request(pick_level(), pick_level());
		offer_request(pick_level(), pick_level());

		wait_results_done();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
